FILE: rtl/core/positional_list_insert_delete_defines.svh
// Assertion macros for the positional list block.
// Used by the top level only; no other dependencies.
`ifndef POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled in reset.
`define PLI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled in reset.
`define PLI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PLI_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define PLI_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/core/pli_pkg.sv
// Shared types and codes for the positional list block.
// No dependencies.
package pli_pkg;

  localparam int POS_W  = 7;
  localparam int DATA_W = 32;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_DUMP   = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  typedef enum logic {
    STATE_IDLE,
    STATE_DUMP
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t           op;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   cnt;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/positional_list_insert_delete.sv
// Top level of the positional list: a chain of entry cells and its controller.
// Depends on pli_pkg, pli_cell, pli_ctrl and the assertion macro header.
//
//  channel   ports                         handshake
//  --------  ----------------------------  ---------------------------------
//  request   func, position, value         taken when start && !busy
//  result    status, count, element,       one cycle, marked by done;
//            is_last                       always taken
//
// Insert, delete and error requests: result on the next cycle, a new request
// every cycle while busy is low. Dump of n entries: busy while the chain rotates
// one entry out of cell 0 per cycle; results run one per cycle, registered
// after the dump state, the last with busy low.
// Reset (rst, synchronous) empties the list; cell contents stay undefined.
// The receiver cannot stall, so nothing ever waits on the result side.
`include "positional_list_insert_delete_defines.svh"
module positional_list_insert_delete #(
  parameter int LIST_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         func,
  input  logic [pli_pkg::POS_W-1:0]          position,
  input  logic signed [pli_pkg::DATA_W-1:0]  value,
  output logic                               done,
  output logic [1:0]                         status,
  output logic [pli_pkg::POS_W-1:0]          count,
  output logic signed [pli_pkg::DATA_W-1:0]  element,
  output logic                               is_last
);
  import pli_pkg::*;

  // Cell i holds list entry i; only cells below the count are meaningful.
  logic signed [DATA_W-1:0] cell_data [LIST_DEPTH];
  cell_ctrl_t               ctl;
  logic                     accept;

  assign accept = start && !busy;

  pli_ctrl #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .func      (func),
    .position  (position),
    .head_data (cell_data[0]),
    .busy      (busy),
    .ctl       (ctl),
    .done      (done),
    .status    (status),
    .count     (count),
    .element   (element),
    .is_last   (is_last)
  );

  // Each cell sees both neighbors: insert shifts up (from the left),
  // delete and dump rotation shift down (from the right).
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    pli_cell #(
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .ins_value  (value),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (cell_data[0]),
      .data       (cell_data[i])
    );
  end

  // Non-dump requests give exactly one, final result next cycle.
  `PLI_ASSERT_NEXT(a_single_result, clk, rst, accept && func != FUNC_DUMP,
    done && is_last, "single-result request gave no final result")
  // Every dump cycle delivers one entry.
  `PLI_ASSERT_NEXT(a_dump_emits, clk, rst, busy, done,
    "dump cycle produced no result")
  // A non-final result only ever comes from a running dump.
  `PLI_ASSERT_IMPL(a_nonlast_in_dump, clk, rst, done && !is_last, busy,
    "non-final result outside a dump")
  // The count cannot change while a dump is running.
  `PLI_ASSERT_NEXT(a_dump_count, clk, rst, busy && done, count == $past(count),
    "count changed during dump")

endmodule

FILE: rtl/core/pli_cell.sv
// One storage cell of the list chain.
// Depends on pli_pkg.
module pli_cell #(
  parameter int INDEX = 0
) (
  input  logic                               clk,
  input  pli_pkg::cell_ctrl_t                ctl,
  input  logic signed [pli_pkg::DATA_W-1:0]  ins_value,
  input  logic signed [pli_pkg::DATA_W-1:0]  left_data,
  input  logic signed [pli_pkg::DATA_W-1:0]  right_data,
  input  logic signed [pli_pkg::DATA_W-1:0]  head_data,
  output logic signed [pli_pkg::DATA_W-1:0]  data
);
  import pli_pkg::*;

  localparam logic [POS_W-1:0] IDX  = POS_W'(INDEX);
  localparam logic [POS_W-1:0] IDX1 = POS_W'(INDEX + 1);

  logic signed [DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (ctl.op)
      CELL_HOLD: begin
        data_next = data;
      end
      CELL_INSERT: begin
        if (IDX > ctl.pos) begin
          data_next = left_data;
        end else if (IDX == ctl.pos) begin
          data_next = ins_value;
        end
      end
      CELL_DELETE: begin
        if (IDX >= ctl.pos) begin
          data_next = right_data;
        end
      end
      CELL_ROTATE: begin
        // rotate the occupied part left by one; the head wraps to the tail
        if (IDX1 < ctl.cnt) begin
          data_next = right_data;
        end else if (IDX1 == ctl.cnt) begin
          data_next = head_data;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

FILE: rtl/core/pli_ctrl.sv
// Request decode, entry count, dump sequencer and result registers.
// Depends on pli_pkg.
module pli_ctrl #(
  parameter int LIST_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [1:0]                         func,
  input  logic [pli_pkg::POS_W-1:0]          position,
  input  logic signed [pli_pkg::DATA_W-1:0]  head_data,
  output logic                               busy,
  output pli_pkg::cell_ctrl_t                ctl,
  output logic                               done,
  output logic [1:0]                         status,
  output logic [pli_pkg::POS_W-1:0]          count,
  output logic signed [pli_pkg::DATA_W-1:0]  element,
  output logic                               is_last
);
  import pli_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(LIST_DEPTH);

  state_t                   state, state_next;
  logic [CW-1:0]            entry_count, entry_count_next;
  logic [CW-1:0]            dump_idx, dump_idx_next;
  logic                     accept;
  logic                     dump_last;
  logic [POS_W-1:0]         cnt_ext;

  logic                     done_next;
  logic [1:0]               status_next;
  logic signed [DATA_W-1:0] element_next;
  logic                     is_last_next;

  assign busy      = (state == STATE_DUMP);
  assign accept    = start && !busy;
  assign cnt_ext   = POS_W'(entry_count);
  assign dump_last = (dump_idx == entry_count - CW'(1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      STATE_IDLE: begin
        if (accept && func == FUNC_DUMP && entry_count != '0) begin
          state_next = STATE_DUMP;
        end
      end
      STATE_DUMP: begin
        if (dump_last) begin
          state_next = STATE_IDLE;
        end
      end
      default: state_next = STATE_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    ctl.op           = CELL_HOLD;
    ctl.pos          = position;
    ctl.cnt          = cnt_ext;
    entry_count_next = entry_count;
    dump_idx_next    = dump_idx;
    done_next        = 1'b0;
    status_next      = STAT_OK;
    element_next     = '0;
    is_last_next     = 1'b1;
    case (state)
      STATE_IDLE: begin
        dump_idx_next = '0;
        if (accept) begin
          done_next = 1'b1;
          case (func)
            FUNC_INSERT: begin
              if (entry_count == FULL_CNT) begin
                status_next = STAT_FULL;
              end else if (position > cnt_ext) begin
                status_next = STAT_RANGE;
              end else begin
                ctl.op           = CELL_INSERT;
                entry_count_next = entry_count + CW'(1);
              end
            end
            FUNC_DELETE: begin
              if (entry_count == '0) begin
                status_next = STAT_EMPTY;
              end else if (position >= cnt_ext) begin
                status_next = STAT_RANGE;
              end else begin
                ctl.op           = CELL_DELETE;
                entry_count_next = entry_count - CW'(1);
              end
            end
            FUNC_DUMP: begin
              if (entry_count == '0) begin
                status_next = STAT_EMPTY;
              end else begin
                done_next = 1'b0;
              end
            end
            default: status_next = STAT_RANGE;
          endcase
        end
      end
      STATE_DUMP: begin
        ctl.op        = CELL_ROTATE;
        done_next     = 1'b1;
        element_next  = head_data;
        is_last_next  = dump_last;
        dump_idx_next = dump_idx + CW'(1);
      end
      default: begin
        ctl.op = CELL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= STATE_IDLE;
      entry_count <= '0;
      dump_idx    <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      dump_idx    <= dump_idx_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    status  <= status_next;
    count   <= POS_W'(entry_count_next);
    element <= element_next;
    is_last <= is_last_next;
  end

endmodule
